FILE: sv/framebuffer_rect_draw_engine_unit_assert.svh
// Assertion macros shared by the frame store drawing engine.
`ifndef FRAMEBUFFER_RECT_DRAW_ENGINE_UNIT_ASSERT_SVH
`define FRAMEBUFFER_RECT_DRAW_ENGINE_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define FRB_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define FRB_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`endif

FILE: sv/frb_pkg.sv
// Shared constants and types of the frame store drawing engine.
package frb_pkg;

  localparam int FRAME_WIDTH_DEF  = 128;
  localparam int FRAME_HEIGHT_DEF = 32;
  localparam int COORD_W          = 8;

  localparam logic [2:0] MODE_LINE  = 3'd0;
  localparam logic [2:0] MODE_RECT  = 3'd1;
  localparam logic [2:0] MODE_CUT   = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_SHIFT = 3'd4;
  localparam logic [2:0] MODE_READ  = 3'd5;

  localparam logic [1:0] PIX_CLEAR = 2'd0;
  localparam logic [1:0] PIX_OFF   = 2'd1;
  localparam logic [1:0] PIX_ON    = 2'd2;
  localparam logic [1:0] PIX_BAD   = 2'd3;

  // Signed coordinate wide enough for x + width - 1 and x - 1
  typedef logic signed [9:0] coord_t;

  typedef struct packed {
    logic               load;
    logic               step;
    logic               x_down;
    logic               y_down;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
  } walk_cmd_t;

  typedef struct packed {
    logic               nonempty;
    logic [COORD_W-1:0] lo_x;
    logic [COORD_W-1:0] hi_x;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W-1:0] hi_y;
  } clip_t;

endpackage

FILE: sv/frb_mem.sv
// Frame store memory: one write port, one registered read port.
module frb_mem #(
  parameter int ADDR_W = $clog2(frb_pkg::FRAME_WIDTH_DEF) + $clog2(frb_pkg::FRAME_HEIGHT_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [1:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [1:0]        rdata
);
  logic [1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: sv/frb_walker.sv
// Box walker: steps a pixel position over a box, column by column.
module frb_walker #(
  parameter int FRAME_WIDTH  = frb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = frb_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                            clk,
  input  frb_pkg::walk_cmd_t              cmd,
  output logic [$clog2(FRAME_WIDTH)-1:0]  cx,
  output logic [$clog2(FRAME_HEIGHT)-1:0] cy,
  output logic                            last
);
  import frb_pkg::*;

  localparam int CXW = $clog2(FRAME_WIDTH);
  localparam int CYW = $clog2(FRAME_HEIGHT);

  logic [CXW-1:0] xe;
  logic [CYW-1:0] ys;
  logic [CYW-1:0] ye;
  logic           xdn;
  logic           ydn;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xdn <= cmd.x_down;
      ydn <= cmd.y_down;
      cx  <= cmd.x_down ? cmd.x1[CXW-1:0] : cmd.x0[CXW-1:0];
      xe  <= cmd.x_down ? cmd.x0[CXW-1:0] : cmd.x1[CXW-1:0];
      cy  <= cmd.y_down ? cmd.y1[CYW-1:0] : cmd.y0[CYW-1:0];
      ys  <= cmd.y_down ? cmd.y1[CYW-1:0] : cmd.y0[CYW-1:0];
      ye  <= cmd.y_down ? cmd.y0[CYW-1:0] : cmd.y1[CYW-1:0];
    end else if (cmd.step) begin
      if (cy == ye) begin
        // wrap to the top of the next column
        cy <= ys;
        cx <= xdn ? cx - 1'b1 : cx + 1'b1;
      end else begin
        cy <= ydn ? cy - 1'b1 : cy + 1'b1;
      end
    end
  end

  assign last = (cx == xe) && (cy == ye);
endmodule

FILE: sv/framebuffer_rect_draw_engine_unit.sv
// Top level of the frame store drawing engine: command sequencer and result register.
//
// Usage: one command item enters on in_valid/in_ready with its mode and operands; every
// command returns exactly one result item on out_valid/out_ready (read_state,
// display_write, display_level). Drawing, clear and shift commands return an all-zero
// result once their last pixel is written; a read returns the addressed pixel.
// in_ready is high only while the sequencer is idle, so one command is in work at a time.
// Work per command, all done by the single box walker that visits one pixel per step:
//   line / rectangle: each of the 4 boxes is loaded in turn and its pixels written
//   clear:            every pixel of the frame is written
//   shift:            each pixel's source is read, then the pixel is written; a zero
//                     shift skips the walk
//   read pixel:       one read of the store; unused modes go straight to the result
// Reset runs a clearing pass over the store with in_ready low. A finished result waits
// in the output register while the receiver stalls; the next command is accepted
// meanwhile, and the sequencer holds its own result only if the register is still
// full when it finishes.
`include "framebuffer_rect_draw_engine_unit_assert.svh"

module framebuffer_rect_draw_engine_unit #(
  parameter int FRAME_WIDTH  = frb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = frb_pkg::FRAME_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        mode,
  input  logic [7:0]        x,
  input  logic [7:0]        y,
  input  logic [7:0]        x_end,
  input  logic [7:0]        y_end,
  input  logic [7:0]        width,
  input  logic [7:0]        height,
  input  logic              fill,
  input  logic [1:0]        pixel_value,
  input  logic signed [7:0] shift_x,
  input  logic signed [7:0] shift_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        read_state,
  output logic              display_write,
  output logic              display_level
);
  import frb_pkg::*;

  localparam int CXW = $clog2(FRAME_WIDTH);
  localparam int CYW = $clog2(FRAME_HEIGHT);
  localparam int AW  = CXW + CYW;

  localparam coord_t             XMAX   = coord_t'(FRAME_WIDTH - 1);
  localparam coord_t             YMAX   = coord_t'(FRAME_HEIGHT - 1);
  localparam logic [COORD_W-1:0] XMAX_C = COORD_W'(FRAME_WIDTH - 1);
  localparam logic [COORD_W-1:0] YMAX_C = COORD_W'(FRAME_HEIGHT - 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CLR_LOAD = 4'd1;
  localparam logic [3:0] ST_CLR_RUN  = 4'd2;
  localparam logic [3:0] ST_BOX_LOAD = 4'd3;
  localparam logic [3:0] ST_BOX_RUN  = 4'd4;
  localparam logic [3:0] ST_SH_LOAD  = 4'd5;
  localparam logic [3:0] ST_SH_RD    = 4'd6;
  localparam logic [3:0] ST_SH_WR    = 4'd7;
  localparam logic [3:0] ST_RD_A     = 4'd8;
  localparam logic [3:0] ST_RD_B     = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;

  typedef struct packed {
    logic   valid;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } box_t;

  function automatic box_t mk_box(coord_t a, coord_t b, coord_t c, coord_t d);
    box_t r;
    r.valid = 1'b1;
    r.x0    = a;
    r.y0    = b;
    r.x1    = c;
    r.y1    = d;
    return r;
  endfunction

  // Clamp a box to the frame; an inverted result means nothing to draw.
  function automatic clip_t clip_box(box_t b);
    clip_t  r;
    coord_t lx;
    coord_t hx;
    coord_t ly;
    coord_t hy;
    lx = (b.x0 < 10'sd0) ? 10'sd0 : b.x0;
    hx = (b.x1 > XMAX) ? XMAX : b.x1;
    ly = (b.y0 < 10'sd0) ? 10'sd0 : b.y0;
    hy = (b.y1 > YMAX) ? YMAX : b.y1;
    r.nonempty = b.valid && (lx <= hx) && (ly <= hy);
    r.lo_x     = lx[COORD_W-1:0];
    r.hi_x     = hx[COORD_W-1:0];
    r.lo_y     = ly[COORD_W-1:0];
    r.hi_y     = hy[COORD_W-1:0];
    return r;
  endfunction

  logic [3:0]         state;
  logic               reply;
  box_t               boxes [4];
  box_t               new_box [4];
  logic [1:0]         box_idx;
  logic [1:0]         pv;
  coord_t             sx;
  coord_t             sy;
  logic [7:0]         rx;
  logic [7:0]         ry;
  logic               sh_inb;
  logic               rd_inb;
  logic [1:0]         res_state;
  logic               out_load;

  walk_cmd_t          wcmd;
  clip_t              cur_clip;
  logic [CXW-1:0]     wk_x;
  logic [CYW-1:0]     wk_y;
  logic               wk_last;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [1:0]         mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [1:0]         mem_rdata;

  coord_t             ox;
  coord_t             oy;
  logic               src_inb;
  logic               rd_in_frame;

  assign in_ready = (state == ST_IDLE);

  // Load the output register when a result is ready and the register is free.
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // Break the incoming command into up to four boxes, all drawn with the same value.
  always_comb begin
    coord_t xs;
    coord_t ys;
    coord_t xes;
    coord_t yes;
    coord_t x2;
    coord_t y2;
    logic   drawable;
    logic   sized;
    xs  = {2'b00, x};
    ys  = {2'b00, y};
    xes = {2'b00, x_end};
    yes = {2'b00, y_end};
    x2  = xs + {2'b00, width} - 10'sd1;
    y2  = ys + {2'b00, height} - 10'sd1;
    drawable = (pixel_value != PIX_BAD);
    sized    = (width != 8'd0) && (height != 8'd0);
    for (int i = 0; i < 4; i++) begin
      new_box[i] = '0;
    end
    case (mode)
      MODE_LINE: begin
        if (drawable) begin
          if (x == x_end) begin
            new_box[0] = mk_box(xs, ys, xs, yes);
          end else if (y == y_end) begin
            new_box[0] = mk_box(xs, ys, xes, ys);
          end
        end
      end
      MODE_RECT: begin
        if (drawable && sized) begin
          if (fill) begin
            new_box[0] = mk_box(xs, ys, x2, y2);
          end else begin
            new_box[0] = mk_box(xs, ys, x2, ys);
            new_box[1] = mk_box(xs, y2, x2, y2);
            new_box[2] = mk_box(xs, ys, xs, y2);
            new_box[3] = mk_box(x2, ys, x2, y2);
          end
        end
      end
      MODE_CUT: begin
        if (drawable && sized) begin
          // top and bottom rows lose their end pixels
          new_box[0] = mk_box(xs + 10'sd1, ys, x2 - 10'sd1, ys);
          new_box[1] = mk_box(xs + 10'sd1, y2, x2 - 10'sd1, y2);
          if (fill) begin
            new_box[2] = mk_box(xs, ys + 10'sd1, x2, y2 - 10'sd1);
          end else begin
            new_box[2] = mk_box(xs, ys + 10'sd1, xs, y2 - 10'sd1);
            new_box[3] = mk_box(x2, ys + 10'sd1, x2, y2 - 10'sd1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign cur_clip = clip_box(boxes[box_idx]);

  // Drive the shared walker: load a box or the whole frame, or advance one pixel.
  always_comb begin
    wcmd = '0;
    case (state)
      ST_CLR_LOAD, ST_SH_LOAD: begin
        wcmd.load = 1'b1;
        wcmd.x0   = '0;
        wcmd.x1   = XMAX_C;
        wcmd.y0   = '0;
        wcmd.y1   = YMAX_C;
        // walk away from the source so no pixel is read after it is overwritten
        wcmd.x_down = (state == ST_SH_LOAD) && (sx > 10'sd0);
        wcmd.y_down = (state == ST_SH_LOAD) && (sy > 10'sd0);
      end
      ST_BOX_LOAD: begin
        wcmd.load = cur_clip.nonempty;
        wcmd.x0   = cur_clip.lo_x;
        wcmd.x1   = cur_clip.hi_x;
        wcmd.y0   = cur_clip.lo_y;
        wcmd.y1   = cur_clip.hi_y;
      end
      ST_BOX_RUN, ST_CLR_RUN, ST_SH_WR: begin
        wcmd.step = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Source pixel of a shift, and whether it lies inside the frame.
  assign ox = coord_t'({{(10 - CXW){1'b0}}, wk_x}) - sx;
  assign oy = coord_t'({{(10 - CYW){1'b0}}, wk_y}) - sy;
  assign src_inb = (ox >= 10'sd0) && (ox <= XMAX) && (oy >= 10'sd0) && (oy <= YMAX);
  assign rd_in_frame = (coord_t'({2'b00, rx}) <= XMAX) && (coord_t'({2'b00, ry}) <= YMAX);

  // Store port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = PIX_CLEAR;
    mem_waddr = {wk_x, wk_y};
    mem_re    = 1'b0;
    mem_raddr = {ox[CXW-1:0], oy[CYW-1:0]};
    case (state)
      ST_BOX_RUN: begin
        mem_we    = 1'b1;
        mem_wdata = pv;
      end
      ST_CLR_RUN: begin
        mem_we    = 1'b1;
        mem_wdata = PIX_CLEAR;
      end
      ST_SH_RD: begin
        mem_re = 1'b1;
      end
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = sh_inb ? mem_rdata : PIX_CLEAR;
      end
      ST_RD_A: begin
        mem_re    = 1'b1;
        mem_raddr = {rx[CXW-1:0], ry[CYW-1:0]};
      end
      default: begin
      end
    endcase
  end

  frb_walker #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_walker (
    .clk  (clk),
    .cmd  (wcmd),
    .cx   (wk_x),
    .cy   (wk_y),
    .last (wk_last)
  );

  frb_mem #(
    .ADDR_W (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR_LOAD;
      reply     <= 1'b0;
      box_idx   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < 4; i++) begin
              boxes[i] <= new_box[i];
            end
            box_idx   <= 2'd0;
            pv        <= pixel_value;
            sx        <= {{2{shift_x[7]}}, shift_x};
            sy        <= {{2{shift_y[7]}}, shift_y};
            rx        <= x;
            ry        <= y;
            res_state <= PIX_CLEAR;
            case (mode)
              MODE_LINE, MODE_RECT, MODE_CUT: begin
                state <= ST_BOX_LOAD;
              end
              MODE_CLEAR: begin
                reply <= 1'b1;
                state <= ST_CLR_LOAD;
              end
              MODE_SHIFT: begin
                if ((shift_x == 8'sd0) && (shift_y == 8'sd0)) begin
                  state <= ST_DONE;
                end else begin
                  state <= ST_SH_LOAD;
                end
              end
              MODE_READ: begin
                state <= ST_RD_A;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_CLR_LOAD: begin
          state <= ST_CLR_RUN;
        end
        ST_CLR_RUN: begin
          if (wk_last) begin
            // the pass after reset owes no result
            state <= reply ? ST_DONE : ST_IDLE;
          end
        end
        ST_BOX_LOAD: begin
          if (wcmd.load) begin
            state <= ST_BOX_RUN;
          end else if (box_idx == 2'd3) begin
            state <= ST_DONE;
          end else begin
            box_idx <= box_idx + 2'd1;
          end
        end
        ST_BOX_RUN: begin
          if (wk_last) begin
            if (box_idx == 2'd3) begin
              state <= ST_DONE;
            end else begin
              box_idx <= box_idx + 2'd1;
              state   <= ST_BOX_LOAD;
            end
          end
        end
        ST_SH_LOAD: begin
          state <= ST_SH_RD;
        end
        ST_SH_RD: begin
          sh_inb <= src_inb;
          state  <= ST_SH_WR;
        end
        ST_SH_WR: begin
          state <= wk_last ? ST_DONE : ST_SH_RD;
        end
        ST_RD_A: begin
          rd_inb <= rd_in_frame;
          state  <= ST_RD_B;
        end
        ST_RD_B: begin
          res_state <= rd_inb ? mem_rdata : PIX_CLEAR;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          // hold the result until the output register is free
          if (out_load) begin
            read_state    <= res_state;
            display_write <= (res_state == PIX_OFF) || (res_state == PIX_ON);
            display_level <= (res_state == PIX_ON);
            reply         <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `FRB_ASSERT_IMP(a_idle_no_write, (state == ST_IDLE), !mem_we, "store written while idle")
  `FRB_ASSERT_IMP(a_write_in_frame, mem_we,
    (int'(wk_x) < FRAME_WIDTH) && (int'(wk_y) < FRAME_HEIGHT), "write outside frame")
  `FRB_ASSERT_NXT(a_accept_busy, in_valid && in_ready, state != ST_IDLE,
    "accepted item left sequencer idle")
  `FRB_ASSERT_IMP(a_level_needs_write, out_valid && display_level,
    display_write && (read_state == PIX_ON), "display level without write strobe")

endmodule

FILE: bench/frb_canvas_checker.sv
// Pixel store predictor and result comparator for the frame store drawing engine.
module frb_canvas_checker #(
  parameter int FW = frb_pkg::FRAME_WIDTH_DEF,
  parameter int FH = frb_pkg::FRAME_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        mode,
  input  logic [7:0]        x,
  input  logic [7:0]        y,
  input  logic [7:0]        x_end,
  input  logic [7:0]        y_end,
  input  logic [7:0]        width,
  input  logic [7:0]        height,
  input  logic              fill,
  input  logic [1:0]        pixel_value,
  input  logic signed [7:0] shift_x,
  input  logic signed [7:0] shift_y,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        read_state,
  input  logic              display_write,
  input  logic              display_level,
  output int                fail_count,
  output int                awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import frb_pkg::*;

  typedef struct packed {
    logic [1:0] state;
    logic       write;
    logic       level;
  } readout_t;

  logic [1:0] canvas [FW][FH];
  readout_t   readout_q [$];
  int         fails = 0;

  assign fail_count = fails;

  // Paint an inclusive box, clipped to the frame.
  function automatic void paint(int x0, int y0, int x1, int y1, logic [1:0] v);
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > FW - 1) x1 = FW - 1;
    if (y1 > FH - 1) y1 = FH - 1;
    for (int cx = x0; cx <= x1; cx++)
      for (int cy = y0; cy <= y1; cy++)
        canvas[cx][cy] = v;
  endfunction

  // Move the whole frame by (dx, dy); vacated pixels turn transparent.
  function automatic void slide(int dx, int dy);
    logic [1:0] moved [FW][FH];
    int ox, oy;
    if (dx == 0 && dy == 0) return;
    for (int cx = 0; cx < FW; cx++)
      for (int cy = 0; cy < FH; cy++) begin
        ox = cx - dx;
        oy = cy - dy;
        moved[cx][cy] = (ox >= 0 && ox < FW && oy >= 0 && oy < FH) ? canvas[ox][oy]
                                                                    : PIX_CLEAR;
      end
    for (int cx = 0; cx < FW; cx++)
      for (int cy = 0; cy < FH; cy++)
        canvas[cx][cy] = moved[cx][cy];
  endfunction

  // Apply the command on the ports to the canvas and return its readout.
  function automatic readout_t predict_readout();
    int         x0    = int'(x);
    int         y0    = int'(y);
    int         x1    = x0 + int'(width) - 1;
    int         y1    = y0 + int'(height) - 1;
    logic [1:0] v     = pixel_value;
    logic       draws = (pixel_value != PIX_BAD);
    logic       sized = (width != 0) && (height != 0);
    readout_t   r     = '0;
    case (mode)
      MODE_LINE: begin
        if (draws) begin
          if (x == x_end) paint(x0, y0, x0, int'(y_end), v);
          else if (y == y_end) paint(x0, y0, int'(x_end), y0, v);
        end
      end
      MODE_RECT: begin
        if (draws && sized) begin
          if (fill) begin
            paint(x0, y0, x1, y1, v);
          end else begin
            paint(x0, y0, x1, y0, v);
            paint(x0, y1, x1, y1, v);
            paint(x0, y0, x0, y1, v);
            paint(x1, y0, x1, y1, v);
          end
        end
      end
      MODE_CUT: begin
        if (draws && sized) begin
          paint(x0 + 1, y0, x1 - 1, y0, v);
          paint(x0 + 1, y1, x1 - 1, y1, v);
          if (fill) begin
            paint(x0, y0 + 1, x1, y1 - 1, v);
          end else begin
            paint(x0, y0 + 1, x0, y1 - 1, v);
            paint(x1, y0 + 1, x1, y1 - 1, v);
          end
        end
      end
      MODE_CLEAR: paint(0, 0, FW - 1, FH - 1, PIX_CLEAR);
      MODE_SHIFT: slide(int'(shift_x), int'(shift_y));
      MODE_READ: begin
        if (x0 < FW && y0 < FH) begin
          r.state = canvas[x0][y0];
          r.write = (r.state == PIX_OFF) || (r.state == PIX_ON);
          r.level = (r.state == PIX_ON);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want_v);
    fails++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want_v);
  endtask

  always @(posedge clk) begin : watch
    readout_t want;
    if (rst) begin
      paint(0, 0, FW - 1, FH - 1, PIX_CLEAR);
      readout_q.delete();
      awaiting <= 0;
    end else begin
      // Retire the result first so it pairs with an earlier command.
      if (out_valid && out_ready) begin
        if (readout_q.size() == 0) begin
          report_mismatch("result with none awaited, read_state", int'(read_state), 0);
        end else begin
          want = readout_q.pop_front();
          if (read_state !== want.state)
            report_mismatch("read_state", int'(read_state), int'(want.state));
          if (display_write !== want.write)
            report_mismatch("display_write", int'(display_write), int'(want.write));
          if (display_level !== want.level)
            report_mismatch("display_level", int'(display_level), int'(want.level));
        end
      end
      if (in_valid && in_ready) readout_q.push_back(predict_readout());
      awaiting <= readout_q.size();
    end
  end

endmodule

FILE: bench/framebuffer_rect_draw_engine_unit_tb.sv
// Stimulus, clock, reset and verdict for the frame store drawing engine.
module framebuffer_rect_draw_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frb_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int FW            = FRAME_WIDTH_DEF;
  localparam int FH            = FRAME_HEIGHT_DEF;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int SETTLE_EVERY  = 250;
  localparam int GAP_MAX       = 10;
  localparam int BURST_MAX     = 16;
  localparam int RX_HOLD_MAX   = 24;
  localparam int SETTLE_CYCLES = 64;

  // Modes the block does not define; they must change nothing.
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic [2:0]        mode;
    logic [7:0]        x;
    logic [7:0]        y;
    logic [7:0]        xe;
    logic [7:0]        ye;
    logic [7:0]        w;
    logic [7:0]        h;
    logic              fill;
    logic [1:0]        pv;
    logic signed [7:0] sx;
    logic signed [7:0] sy;
  } draw_cmd_t;

  // Receiver behavior: always ready, randomly ready three times in four, or long held levels.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_LONG} rx_style_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [2:0]        mode          = MODE_LINE;
  logic [7:0]        x             = '0;
  logic [7:0]        y             = '0;
  logic [7:0]        x_end         = '0;
  logic [7:0]        y_end         = '0;
  logic [7:0]        width         = '0;
  logic [7:0]        height        = '0;
  logic              fill          = 1'b0;
  logic [1:0]        pixel_value   = PIX_CLEAR;
  logic signed [7:0] shift_x       = '0;
  logic signed [7:0] shift_y       = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [1:0]        read_state;
  logic              display_write;
  logic              display_level;

  int                fail_count;
  int                awaiting;

  int                burst_left    = 0;
  longint            cycle_budget  = 0;
  longint            cycles        = 0;
  rx_style_t         rx_style      = RX_OPEN;
  int                rx_left       = 0;
  int                rx_hold       = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  framebuffer_rect_draw_engine_unit #(
    .FRAME_WIDTH  (FW),
    .FRAME_HEIGHT (FH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .x             (x),
    .y             (y),
    .x_end         (x_end),
    .y_end         (y_end),
    .width         (width),
    .height        (height),
    .fill          (fill),
    .pixel_value   (pixel_value),
    .shift_x       (shift_x),
    .shift_y       (shift_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_state    (read_state),
    .display_write (display_write),
    .display_level (display_level)
  );

  frb_canvas_checker #(
    .FW (FW),
    .FH (FH)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .x             (x),
    .y             (y),
    .x_end         (x_end),
    .y_end         (y_end),
    .width         (width),
    .height        (height),
    .fill          (fill),
    .pixel_value   (pixel_value),
    .shift_x       (shift_x),
    .shift_y       (shift_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_state    (read_state),
    .display_write (display_write),
    .display_level (display_level),
    .fail_count    (fail_count),
    .awaiting      (awaiting)
  );

  // Receiver: switch style from time to time so stalls land on every
  // phase of a command, including long open stretches with no stall at all.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style <= rx_style_t'($urandom_range(0, 2));
      rx_left  <= $urandom_range(100, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold == 0) begin
          out_ready <= ~out_ready;
          rx_hold   <= $urandom_range(1, RX_HOLD_MAX);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  // Watchdog: the budget grows with each command by its worst-case cost, so
  // the limit tracks what was actually sent, with a wide margin on top.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4 * cycle_budget + 4 * FW * FH + 10000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic draw_cmd_t make_cmd(logic [2:0] m, int px, int py, int pxe, int pye,
                                         int pw, int ph, bit pf, logic [1:0] v,
                                         int dx, int dy);
    draw_cmd_t c;
    c.mode = m;
    c.x    = 8'(px);
    c.y    = 8'(py);
    c.xe   = 8'(pxe);
    c.ye   = 8'(pye);
    c.w    = 8'(pw);
    c.h    = 8'(ph);
    c.fill = pf;
    c.pv   = v;
    c.sx   = 8'(dx);
    c.sy   = 8'(dy);
    return c;
  endfunction

  // Build one random command. Every field starts fully random so that all
  // input bits toggle; the fields that matter for the mode are then shaped
  // to land inside the frame most of the time.
  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int pick, shape;
    c.x    = 8'($urandom);
    c.y    = 8'($urandom);
    c.xe   = 8'($urandom);
    c.ye   = 8'($urandom);
    c.w    = 8'($urandom);
    c.h    = 8'($urandom);
    c.fill = 1'($urandom);
    c.sx   = 8'($urandom);
    c.sy   = 8'($urandom);
    c.pv   = ($urandom_range(0, 19) == 0) ? PIX_BAD : 2'($urandom_range(0, 2));
    pick   = $urandom_range(0, 999);
    shape  = $urandom_range(0, 9);
    if (pick < 350) begin
      c.mode = MODE_READ;
      if (shape != 0) begin
        c.x = 8'($urandom_range(0, FW - 1));
        c.y = 8'($urandom_range(0, FH - 1));
      end
    end else if (pick < 550) begin
      c.mode = MODE_LINE;
      if ($urandom_range(0, 9) != 0) begin
        c.x  = 8'($urandom_range(0, FW - 1));
        c.xe = 8'($urandom_range(0, FW - 1));
        c.y  = 8'($urandom_range(0, FH - 1));
        c.ye = 8'($urandom_range(0, FH - 1));
      end
      // Mostly straight lines; the rest stay diagonal, and reversed ends
      // come up on their own.
      if (shape < 4) c.ye = c.y;
      else if (shape < 8) c.xe = c.x;
      else if (shape == 8) begin
        c.xe = c.x;
        c.ye = c.y;
      end
    end else if (pick < 930) begin
      c.mode = (pick < 750) ? MODE_RECT : MODE_CUT;
      if ($urandom_range(0, 6) != 0) begin
        c.x = 8'($urandom_range(0, FW - 1));
        c.y = 8'($urandom_range(0, FH - 1));
      end
      // Keep most boxes small; a few take full size to exercise clipping.
      if ($urandom_range(0, 29) != 0) begin
        c.w = 8'($urandom_range(0, 12));
        c.h = 8'($urandom_range(0, 12));
      end
    end else if (pick < 945) begin
      c.mode = MODE_CLEAR;
    end else if (pick < 965) begin
      c.mode = MODE_SHIFT;
      if (shape == 0) begin
        c.sx = '0;
        c.sy = '0;
      end else if (shape > 2) begin
        c.sx = 8'(int'($urandom_range(0, 8)) - 4);
        c.sy = 8'(int'($urandom_range(0, 8)) - 4);
      end
    end else begin
      c.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
    end
    return c;
  endfunction

  // Offer one item. Items go out in bursts with valid held high; between
  // bursts valid drops for a random gap (sometimes none at all).
  task automatic send_cmd(input draw_cmd_t c);
    int gap, cost;
    case (c.mode)
      MODE_SHIFT:         cost = 2 * FW * FH + 4;
      MODE_CLEAR:         cost = FW * FH + 4;
      MODE_LINE:          cost = FW + FH + 8;
      MODE_RECT, MODE_CUT:
        cost = (c.w < FW ? c.w : FW) * (c.h < FH ? c.h : FH) + 2 * (FW + FH) + 8;
      default:            cost = 8;
    endcase
    cycle_budget += cost + GAP_MAX + RX_HOLD_MAX;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, BURST_MAX);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GAP_MAX);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    mode        <= c.mode;
    x           <= c.x;
    y           <= c.y;
    x_end       <= c.xe;
    y_end       <= c.ye;
    width       <= c.w;
    height      <= c.h;
    fill        <= c.fill;
    pixel_value <= c.pv;
    shift_x     <= c.sx;
    shift_y     <= c.sy;
    // Hold the item until the block takes it.
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Drop valid and wait until every awaited result has come back.
  task automatic settle();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (awaiting != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. A fresh store reads transparent.
    send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, PIX_CLEAR, 0, 0));
    // Straight lines running past the frame edge, a single point, then
    // a diagonal, a reversed line and an undefined pixel value (no-ops).
    send_cmd(make_cmd(MODE_LINE, 0, 0, 255, 0, 0, 0, 0, PIX_ON, 0, 0));
    send_cmd(make_cmd(MODE_LINE, 127, 0, 127, 255, 0, 0, 0, PIX_OFF, 0, 0));
    send_cmd(make_cmd(MODE_LINE, 5, 5, 5, 5, 0, 0, 0, PIX_ON, 0, 0));
    send_cmd(make_cmd(MODE_LINE, 1, 1, 10, 10, 0, 0, 0, PIX_ON, 0, 0));
    send_cmd(make_cmd(MODE_LINE, 20, 3, 10, 3, 0, 0, 0, PIX_ON, 0, 0));
    send_cmd(make_cmd(MODE_LINE, 0, 10, 127, 10, 0, 0, 0, PIX_BAD, 0, 0));
    // Rectangles: outline, a full-size fill clipped at the far corner, one
    // entirely outside the frame, and zero-width / zero-height boxes.
    send_cmd(make_cmd(MODE_RECT, 10, 12, 0, 0, 6, 4, 0, PIX_OFF, 0, 0));
    send_cmd(make_cmd(MODE_RECT, 100, 20, 0, 0, 255, 255, 1, PIX_ON, 0, 0));
    send_cmd(make_cmd(MODE_RECT, 255, 255, 0, 0, 255, 255, 1, PIX_ON, 0, 0));
    send_cmd(make_cmd(MODE_RECT, 40, 4, 0, 0, 0, 5, 1, PIX_ON, 0, 0));
    send_cmd(make_cmd(MODE_CUT, 40, 4, 0, 0, 5, 0, 1, PIX_ON, 0, 0));
    // Cut-corner boxes: one and two pixels wide, then outline and filled.
    send_cmd(make_cmd(MODE_CUT, 30, 8, 0, 0, 1, 5, 1, PIX_ON, 0, 0));
    send_cmd(make_cmd(MODE_CUT, 34, 8, 0, 0, 2, 3, 0, PIX_OFF, 0, 0));
    send_cmd(make_cmd(MODE_CUT, 50, 2, 0, 0, 8, 6, 0, PIX_ON, 0, 0));
    send_cmd(make_cmd(MODE_CUT, 60, 2, 0, 0, 8, 6, 1, PIX_OFF, 0, 0));
    // Reads of an overdrawn pixel, a read outside the frame, a cut corner.
    send_cmd(make_cmd(MODE_READ, 127, 0, 0, 0, 0, 0, 0, PIX_CLEAR, 0, 0));
    send_cmd(make_cmd(MODE_READ, 255, 255, 0, 0, 0, 0, 0, PIX_CLEAR, 0, 0));
    send_cmd(make_cmd(MODE_READ, 50, 2, 0, 0, 0, 0, 0, PIX_CLEAR, 0, 0));
    // Zero shift, a small shift, then the extreme offsets.
    send_cmd(make_cmd(MODE_SHIFT, 0, 0, 0, 0, 0, 0, 0, PIX_CLEAR, 0, 0));
    send_cmd(make_cmd(MODE_SHIFT, 0, 0, 0, 0, 0, 0, 0, PIX_CLEAR, 3, -2));
    send_cmd(make_cmd(MODE_READ, 8, 3, 0, 0, 0, 0, 0, PIX_CLEAR, 0, 0));
    send_cmd(make_cmd(MODE_SHIFT, 0, 0, 0, 0, 0, 0, 0, PIX_CLEAR, -128, 127));
    send_cmd(make_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, PIX_CLEAR, 0, 0));
    send_cmd(make_cmd(MODE_READ, 5, 5, 0, 0, 0, 0, 0, PIX_CLEAR, 0, 0));
    // Undefined modes must leave the store alone.
    send_cmd(make_cmd(MODE_SPARE_A, 3, 3, 9, 9, 4, 4, 1, PIX_ON, 1, 1));
    send_cmd(make_cmd(MODE_SPARE_B, 255, 255, 255, 255, 255, 255, 1, PIX_BAD, -1, -1));
    settle();

    // Random part, with a full drain every so often.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_cmd(random_cmd());
      if (i % SETTLE_EVERY == SETTLE_EVERY - 1) settle();
    end
    settle();

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
